// File: src/sam_pkg.sv
// Package: shared constants, codes and types of the stripe address mapper.
package sam_pkg;

	localparam int unsigned OFFSET_W    = 48;
	localparam int unsigned LENGTH_W    = 32;
	localparam int unsigned STRIPE_W    = 31;
	localparam int unsigned COUNT_W     = 3;
	localparam int unsigned CAP_W       = 49;
	localparam int unsigned INDEX_W     = 2;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 49;
	localparam int unsigned DRIVES      = 4;
	localparam int unsigned MAX_DRIVES  = 4;
	localparam int unsigned BLOCK_SIZE  = 4096;

	localparam logic [STRIPE_W-1:0] STRIPE_RESET = STRIPE_W'(65536);
	localparam logic [COUNT_W-1:0]  COUNT_RESET  = COUNT_W'(1);

	typedef enum logic [2:0] {
		ERR_OK       = 3'd0,
		ERR_OFFSET   = 3'd1,
		ERR_LENGTH   = 3'd2,
		ERR_CROSS    = 3'd3,
		ERR_CAPACITY = 3'd4
	} err_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_STRIPE_SIZE = 3'd0,
		REG_DRIVE_COUNT = 3'd1,
		REG_DRIVE0_CAP  = 3'd2,
		REG_DRIVE1_CAP  = 3'd3,
		REG_DRIVE2_CAP  = 3'd4,
		REG_DRIVE3_CAP  = 3'd5
	} reg_index_t;

endpackage

// File: src/sam_if.sv
// Interfaces: request and response channels of the stripe address mapper.
interface sam_req_if;
	logic                           valid;
	logic                           ready;
	logic [sam_pkg::OFFSET_W-1:0]   vol_offset;
	logic [sam_pkg::LENGTH_W-1:0]   request_length;

	modport source (output valid, output vol_offset, output request_length, input ready);
	modport sink   (input valid, input vol_offset, input request_length, output ready);
endinterface

interface sam_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [sam_pkg::INDEX_W-1:0]    drive_index;
	logic [sam_pkg::OFFSET_W-1:0]   disk_offset;
	logic [2:0]                     error_code;

	modport source (output valid, output drive_index, output disk_offset, output error_code,
		input ready);
	modport sink   (input valid, input drive_index, input disk_offset, input error_code,
		output ready);
endinterface

// File: src/stripe_address_mapper_core.sv
// Top level: pipelined striped-volume address mapper; one word per cycle unless stalled.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+--------------------------------------------
//   in_ch    | in  | valid/ready   | vol_offset, request_length
//   out_ch   | out | valid/ready   | drive_index, disk_offset, error_code
//   cfg      | in  | cfg_we        | cfg_index, cfg_data
//
// Takes one word per cycle while the output is not stalled; a result is valid
// once its word has passed all 148 register stages: three 48-stage bit-per-stage
// dividers (offset by stripe size, stripe by drive count, product by drive
// capacity) plus four register stages, the first loaded at the accepting edge.
// Reset clears all valid bits and loads the register defaults.
// A stall at the output freezes every stage at once; in_ch.ready follows it.
module stripe_address_mapper_core #(
	parameter int unsigned BLOCK_SIZE = sam_pkg::BLOCK_SIZE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	sam_req_if.sink                           in_ch,
	sam_rsp_if.source                         out_ch,
	input  logic                              cfg_we,
	input  logic [sam_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [sam_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int unsigned BLK_W = $clog2(BLOCK_SIZE);

	logic [sam_pkg::STRIPE_W-1:0] stripe_q;
	logic [sam_pkg::COUNT_W-1:0]  count_q;
	logic [sam_pkg::CAP_W-1:0]    cap_q [sam_pkg::DRIVES];

	logic [sam_pkg::STRIPE_W-1:0] ssz;
	logic [sam_pkg::COUNT_W-1:0]  nd;
	logic                         en;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stripe_q <= sam_pkg::STRIPE_RESET;
			count_q  <= sam_pkg::COUNT_RESET;
			for (int i = 0; i < sam_pkg::DRIVES; i++) begin
				cap_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				sam_pkg::REG_STRIPE_SIZE: stripe_q <= cfg_data[sam_pkg::STRIPE_W-1:0];
				sam_pkg::REG_DRIVE_COUNT: count_q  <= cfg_data[sam_pkg::COUNT_W-1:0];
				sam_pkg::REG_DRIVE0_CAP:  cap_q[0] <= cfg_data[sam_pkg::CAP_W-1:0];
				sam_pkg::REG_DRIVE1_CAP:  cap_q[1] <= cfg_data[sam_pkg::CAP_W-1:0];
				sam_pkg::REG_DRIVE2_CAP:  cap_q[2] <= cfg_data[sam_pkg::CAP_W-1:0];
				sam_pkg::REG_DRIVE3_CAP:  cap_q[3] <= cfg_data[sam_pkg::CAP_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp stripe size and drive count to legal values
	always_comb begin
		ssz = (stripe_q == '0) ? sam_pkg::STRIPE_W'(1) : stripe_q;
		if (count_q == '0) begin
			nd = sam_pkg::COUNT_W'(1);
		end else if (count_q > sam_pkg::COUNT_W'(sam_pkg::MAX_DRIVES)) begin
			nd = sam_pkg::COUNT_W'(sam_pkg::MAX_DRIVES);
		end else begin
			nd = count_q;
		end
	end

	// Advance all stages unless the output word is held
	assign en          = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	// Alignment checks on entry
	sam_pkg::err_t err_in;
	always_comb begin
		if (in_ch.vol_offset[BLK_W-1:0] != '0) begin
			err_in = sam_pkg::ERR_OFFSET;
		end else if (in_ch.request_length[BLK_W-1:0] != '0) begin
			err_in = sam_pkg::ERR_LENGTH;
		end else begin
			err_in = sam_pkg::ERR_OK;
		end
	end

	// Divide offset by stripe size
	logic                          a_v;
	logic [sam_pkg::OFFSET_W-1:0]  a_q;
	logic [sam_pkg::STRIPE_W-1:0]  a_r;
	logic [sam_pkg::LENGTH_W+2:0]  a_pl;

	sam_div #(.DW(sam_pkg::OFFSET_W), .VW(sam_pkg::STRIPE_W), .PW(sam_pkg::LENGTH_W+3)) u_div_a (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(in_ch.valid && in_ch.ready),
		.dividend(in_ch.vol_offset), .divisor(ssz),
		.pl_in({err_in, in_ch.request_length}),
		.out_valid(a_v), .quotient(a_q), .remainder(a_r), .pl_out(a_pl)
	);

	// Stage 1: stripe-crossing check
	logic                          v_s1;
	logic [sam_pkg::OFFSET_W-1:0]  nr_s1;
	logic [sam_pkg::STRIPE_W-1:0]  off_s1;
	sam_pkg::err_t                 err_s1;
	logic [sam_pkg::LENGTH_W:0]    end_a;
	sam_pkg::err_t                 err_a;

	always_comb begin
		end_a = {2'b00, a_r} + {1'b0, a_pl[sam_pkg::LENGTH_W-1:0]};
		err_a = sam_pkg::err_t'(a_pl[sam_pkg::LENGTH_W+2:sam_pkg::LENGTH_W]);
		if (err_a == sam_pkg::ERR_OK && end_a > {2'b00, ssz}) begin
			err_a = sam_pkg::ERR_CROSS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= a_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nr_s1  <= a_q;
			off_s1 <= a_r;
			err_s1 <= err_a;
		end
	end

	// Divide stripe number by drive count
	logic                          b_v;
	logic [sam_pkg::OFFSET_W-1:0]  b_q;
	logic [sam_pkg::COUNT_W-1:0]   b_r;
	logic [sam_pkg::STRIPE_W+2:0]  b_pl;

	sam_div #(.DW(sam_pkg::OFFSET_W), .VW(sam_pkg::COUNT_W), .PW(sam_pkg::STRIPE_W+3)) u_div_b (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1), .dividend(nr_s1), .divisor(nd),
		.pl_in({err_s1, off_s1}),
		.out_valid(b_v), .quotient(b_q), .remainder(b_r), .pl_out(b_pl)
	);

	// Stage 2: pick capacity, split round times stripe size in two partials
	logic                          v_s2;
	logic [sam_pkg::INDEX_W-1:0]   idx_s2;
	logic [sam_pkg::STRIPE_W-1:0]  off_s2;
	sam_pkg::err_t                 err_s2;
	logic [sam_pkg::CAP_W-1:0]     cap_s2;
	logic [54:0]                   plo_s2;
	logic [54:0]                   phi_s2;
	logic [sam_pkg::INDEX_W-1:0]   idx_b;
	logic [sam_pkg::CAP_W-1:0]     cap_b;
	sam_pkg::err_t                 err_b;

	always_comb begin
		idx_b = b_r[sam_pkg::INDEX_W-1:0];
		cap_b = cap_q[idx_b];
		err_b = sam_pkg::err_t'(b_pl[sam_pkg::STRIPE_W+2:sam_pkg::STRIPE_W]);
		if (err_b == sam_pkg::ERR_OK && cap_b == '0) begin
			err_b = sam_pkg::ERR_CAPACITY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= b_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s2 <= idx_b;
			off_s2 <= b_pl[sam_pkg::STRIPE_W-1:0];
			err_s2 <= err_b;
			cap_s2 <= (cap_b == '0) ? sam_pkg::CAP_W'(1) : cap_b;
			plo_s2 <= b_q[23:0] * ssz;
			phi_s2 <= b_q[47:24] * ssz;
		end
	end

	// Stage 3: add partials; the product never exceeds the offset
	logic                          v_s3;
	logic [sam_pkg::INDEX_W-1:0]   idx_s3;
	logic [sam_pkg::STRIPE_W-1:0]  off_s3;
	sam_pkg::err_t                 err_s3;
	logic [sam_pkg::CAP_W-1:0]     cap_s3;
	logic [sam_pkg::OFFSET_W-1:0]  base_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s3  <= idx_s2;
			off_s3  <= off_s2;
			err_s3  <= err_s2;
			cap_s3  <= cap_s2;
			base_s3 <= plo_s2[47:0] + {phi_s2[23:0], 24'b0};
		end
	end

	// Reduce product modulo drive capacity
	logic                          c_v;
	logic [sam_pkg::OFFSET_W-1:0]  c_q;
	logic [sam_pkg::CAP_W-1:0]     c_r;
	logic [sam_pkg::STRIPE_W+4:0]  c_pl;

	sam_div #(.DW(sam_pkg::OFFSET_W), .VW(sam_pkg::CAP_W), .PW(sam_pkg::STRIPE_W+5)) u_div_c (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s3), .dividend(base_s3), .divisor(cap_s3),
		.pl_in({idx_s3, err_s3, off_s3}),
		.out_valid(c_v), .quotient(c_q), .remainder(c_r), .pl_out(c_pl)
	);

	// Stage 4: output register; zero the address on error
	logic                          v_s4;
	logic [sam_pkg::INDEX_W-1:0]   idx_s4;
	logic [sam_pkg::OFFSET_W-1:0]  doff_s4;
	sam_pkg::err_t                 err_s4;
	sam_pkg::err_t                 err_c;
	logic                          unused_q;

	assign err_c    = sam_pkg::err_t'(c_pl[sam_pkg::STRIPE_W+2:sam_pkg::STRIPE_W]);
	assign unused_q = ^c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= c_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s4 <= err_c;
			if (err_c != sam_pkg::ERR_OK) begin
				idx_s4  <= '0;
				doff_s4 <= '0;
			end else begin
				idx_s4  <= c_pl[sam_pkg::STRIPE_W+4:sam_pkg::STRIPE_W+3];
				doff_s4 <= c_r[sam_pkg::OFFSET_W-1:0]
					+ {{(sam_pkg::OFFSET_W-sam_pkg::STRIPE_W){1'b0}}, c_pl[sam_pkg::STRIPE_W-1:0]}
					+ {{(sam_pkg::OFFSET_W-1){1'b0}}, unused_q & 1'b0};
			end
		end
	end

	assign out_ch.valid        = v_s4;
	assign out_ch.drive_index  = idx_s4;
	assign out_ch.disk_offset  = doff_s4;
	assign out_ch.error_code   = err_s4;

`ifndef NO_ASSERTIONS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.error_code != sam_pkg::ERR_OK)
			|-> (out_ch.drive_index == '0 && out_ch.disk_offset == '0))
		else $error("error word carries a nonzero address");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.error_code <= sam_pkg::ERR_CAPACITY))
		else $error("error code out of range");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.error_code == sam_pkg::ERR_OK)
			|-> ({1'b0, out_ch.drive_index} < nd))
		else $error("drive index beyond drive count");
`endif

endmodule

// File: src/sam_div.sv
// Pipelined restoring divider: one quotient bit per stage, sideband carried along.
module sam_div #(
	parameter int unsigned DW = 48,
	parameter int unsigned VW = 31,
	parameter int unsigned PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	input  logic [PW-1:0] pl_in,
	output logic          out_valid,
	output logic [DW-1:0] quotient,
	output logic [VW-1:0] remainder,
	output logic [PW-1:0] pl_out
);

	logic          v_s   [DW+1];
	logic [DW-1:0] dvd_s [DW+1];
	logic [VW-1:0] rem_s [DW+1];
	logic [VW-1:0] dv_s  [DW+1];
	logic [PW-1:0] pl_s  [DW+1];

	// Feed the first stage straight from the inputs
	assign v_s[0]   = in_valid;
	assign dvd_s[0] = dividend;
	assign rem_s[0] = '0;
	assign dv_s[0]  = divisor;
	assign pl_s[0]  = pl_in;

	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic [VW:0] trial;
		logic [VW:0] diff;
		logic        ge;

		// Bring down the next dividend bit and try a subtract
		always_comb begin
			trial = {rem_s[k], dvd_s[k][DW-1]};
			diff  = trial - {1'b0, dv_s[k]};
			ge    = (trial >= {1'b0, dv_s[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		// Shift quotient bits in as dividend bits leave
		always_ff @(posedge clk) begin
			if (en) begin
				dvd_s[k+1] <= {dvd_s[k][DW-2:0], ge};
				rem_s[k+1] <= ge ? diff[VW-1:0] : trial[VW-1:0];
				dv_s[k+1]  <= dv_s[k];
				pl_s[k+1]  <= pl_s[k];
			end
		end
	end

	assign out_valid = v_s[DW];
	assign quotient  = dvd_s[DW];
	assign remainder = rem_s[DW];
	assign pl_out    = pl_s[DW];

endmodule
